// ===== hdl/phd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phd_pkg
// types, constants and codes shared by the hit detector and beat clock
// ----------------------------------------------------------------------------
package phd_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int TIME_W       = 32;
  localparam int THR_W        = 10;
  localparam int MS_W         = 16;
  localparam int POWER_W      = 16;

  localparam int DIGIT_W      = 4;
  localparam int ALU_STEPS    = TIME_W / DIGIT_W;
  localparam int ALU_CNT_W    = $clog2(ALU_STEPS);

  localparam int Q_FRAC       = 14;
  localparam int QUO_W        = 17;
  localparam int DIV_CNT_W    = $clog2(QUO_W + 1);

  localparam logic [QUO_W-1:0]   Q_ONE     = QUO_W'(16384);
  localparam logic [QUO_W-1:0]   Q_SAT_LIM = QUO_W'(49152);
  localparam logic [POWER_W-1:0] POWER_MIN = 16'h8000;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [THR_W-1:0] THR_RST    = THR_W'(15);
  localparam logic [MS_W-1:0]  HOLD_RST   = MS_W'(153);
  localparam logic [MS_W-1:0]  PERIOD_RST = MS_W'(612);
  localparam logic [MS_W-1:0]  WINDOW_RST = MS_W'(306);

  typedef enum logic [1:0] {
    REG_THRESHOLD,
    REG_HOLDOFF,
    REG_PERIOD,
    REG_WINDOW
  } phd_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALU,
    ST_DIV,
    ST_FIN
  } phd_state_t;

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic [MS_W-1:0]  hold;
    logic [MS_W-1:0]  period;
    logic [MS_W-1:0]  window;
  } phd_cfg_t;

  typedef struct packed {
    logic done;
    logic ge_hit;
    logic ge_beat;
  } phd_alu_st_t;

  typedef struct packed {
    logic               done;
    logic [POWER_W-1:0] power;
  } phd_div_st_t;

endpackage

`default_nettype wire

// ===== hdl/phd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phd_if
// valid/ready channels for the millisecond tick and for the result beat
// ----------------------------------------------------------------------------
interface phd_tick_if
  import phd_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output now_ms, output adc_sample, input ready);
  modport sink   (input valid, input now_ms, input adc_sample, output ready);
endinterface

interface phd_result_if
  import phd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               hit_valid;
  logic [POWER_W-1:0] hit_power;
  logic               beat_valid;
  logic [TIME_W-1:0]  event_time_ms;

  modport source (output valid, output hit_valid, output hit_power, output beat_valid,
                  output event_time_ms, input ready);
  modport sink   (input valid, input hit_valid, input hit_power, input beat_valid,
                  input event_time_ms, output ready);
endinterface

`default_nettype wire

// ===== hdl/phd_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phd_cfg_regs
// apb register file: threshold, holdoff, beat period, hit window
// ----------------------------------------------------------------------------
module phd_cfg_regs
  import phd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output phd_cfg_t                cfg
);

  phd_reg_t reg_idx;
  logic     wr_en;

  assign reg_idx = phd_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr    <= THR_RST;
      cfg.hold   <= HOLD_RST;
      cfg.period <= PERIOD_RST;
      cfg.window <= WINDOW_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg.thr    <= pwdata[THR_W-1:0];
        REG_HOLDOFF:   cfg.hold   <= pwdata[MS_W-1:0];
        REG_PERIOD:    cfg.period <= pwdata[MS_W-1:0];
        REG_WINDOW:    cfg.window <= pwdata[MS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = PDATA_W'(cfg.thr);
      REG_HOLDOFF:   prdata = PDATA_W'(cfg.hold);
      REG_PERIOD:    prdata = PDATA_W'(cfg.period);
      REG_WINDOW:    prdata = PDATA_W'(cfg.window);
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/phd_serial_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phd_serial_alu
// nibble-serial pass over the 32-bit time words: holdoff and beat compares,
// next holdoff and beat times, and the magnitude of the beat offset
// ----------------------------------------------------------------------------
module phd_serial_alu
  import phd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [TIME_W-1:0] next_hit,
  input  wire logic [TIME_W-1:0] next_beat,
  input  wire logic [MS_W-1:0]   hold,
  input  wire logic [MS_W-1:0]   period,
  output phd_alu_st_t            st,
  output logic      [TIME_W-1:0] hit_sum,
  output logic      [TIME_W-1:0] beat_sum,
  output logic      [TIME_W-1:0] mag
);

  logic                 busy;
  logic                 done;
  logic [ALU_CNT_W-1:0] cnt;

  logic [TIME_W-1:0] sr_now, sr_hit, sr_beat, sr_hold, sr_per;
  logic [TIME_W-1:0] sr_d1, sr_d2;
  logic              c_ge, c_d1, c_d2, c_s1, c_s2;

  logic [DIGIT_W:0] t_ge, t_d1, t_d2, t_s1, t_s2;

  // one digit of each chain, lsb first
  always_comb begin
    t_ge = {1'b0, sr_now[DIGIT_W-1:0]} + {1'b0, ~sr_hit[DIGIT_W-1:0]} + (DIGIT_W+1)'(c_ge);
    t_d1 = {1'b0, sr_now[DIGIT_W-1:0]} + {1'b0, ~sr_beat[DIGIT_W-1:0]} + (DIGIT_W+1)'(c_d1);
    t_d2 = {1'b0, sr_beat[DIGIT_W-1:0]} + {1'b0, ~sr_now[DIGIT_W-1:0]} + (DIGIT_W+1)'(c_d2);
    t_s1 = {1'b0, sr_now[DIGIT_W-1:0]} + {1'b0, sr_hold[DIGIT_W-1:0]} + (DIGIT_W+1)'(c_s1);
    t_s2 = {1'b0, sr_beat[DIGIT_W-1:0]} + {1'b0, sr_per[DIGIT_W-1:0]} + (DIGIT_W+1)'(c_s2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ALU_CNT_W'(ALU_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr_now  <= now_ms;
      sr_hit  <= next_hit;
      sr_beat <= next_beat;
      sr_hold <= TIME_W'(hold);
      sr_per  <= TIME_W'(period);
      c_ge    <= 1'b1;
      c_d1    <= 1'b1;
      c_d2    <= 1'b1;
      c_s1    <= 1'b0;
      c_s2    <= 1'b0;
    end else if (busy) begin
      sr_now  <= sr_now  >> DIGIT_W;
      sr_hit  <= sr_hit  >> DIGIT_W;
      sr_beat <= sr_beat >> DIGIT_W;
      sr_hold <= sr_hold >> DIGIT_W;
      sr_per  <= sr_per  >> DIGIT_W;
      sr_d1    <= {t_d1[DIGIT_W-1:0], sr_d1[TIME_W-1:DIGIT_W]};
      sr_d2    <= {t_d2[DIGIT_W-1:0], sr_d2[TIME_W-1:DIGIT_W]};
      hit_sum  <= {t_s1[DIGIT_W-1:0], hit_sum[TIME_W-1:DIGIT_W]};
      beat_sum <= {t_s2[DIGIT_W-1:0], beat_sum[TIME_W-1:DIGIT_W]};
      c_ge    <= t_ge[DIGIT_W];
      c_d1    <= t_d1[DIGIT_W];
      c_d2    <= t_d2[DIGIT_W];
      c_s1    <= t_s1[DIGIT_W];
      c_s2    <= t_s2[DIGIT_W];
    end
  end

  // carry out of a - b means a >= b
  assign st  = '{done: done, ge_hit: c_ge, ge_beat: c_d1};
  assign mag = sr_d1[TIME_W-1] ? sr_d2 : sr_d1;

endmodule

`default_nettype wire

// ===== hdl/phd_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phd_divider
// bit-serial restoring divider: power = 1.0 - offset * 2^14 / window in q2.14,
// one quotient bit per cycle, saturated at -2.0
// ----------------------------------------------------------------------------
module phd_divider
  import phd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] mag,
  input  wire logic [MS_W-1:0]   window,
  output phd_div_st_t            st
);

  localparam int LOW_W = 3;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 big;
  logic [MS_W-1:0]      win;
  logic [MS_W-1:0]      rem;
  logic [QUO_W-1:0]     feed;
  logic [QUO_W-1:0]     quo;

  logic [MS_W-1:0]    win_eff;
  logic [TIME_W-1:0]  win_x8;
  logic [MS_W:0]      trial;
  logic [MS_W:0]      diff;
  logic               qbit;
  logic [POWER_W-1:0] power;

  assign win_eff = (window == '0) ? MS_W'(1) : window;
  assign win_x8  = TIME_W'({win_eff, {LOW_W{1'b0}}});

  always_comb begin
    trial = {rem, feed[QUO_W-1]};
    diff  = trial - {1'b0, win};
    qbit  = (trial >= {1'b0, win});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient fits 17 bits unless offset >= 8 * window
  always_ff @(posedge clk) begin
    if (start) begin
      big  <= (mag >= win_x8);
      win  <= win_eff;
      rem  <= mag[MS_W+LOW_W-1:LOW_W];
      feed <= {mag[LOW_W-1:0], {Q_FRAC{1'b0}}};
      quo  <= '0;
    end else if (busy) begin
      rem  <= qbit ? diff[MS_W-1:0] : trial[MS_W-1:0];
      feed <= feed << 1;
      quo  <= {quo[QUO_W-2:0], qbit};
    end
  end

  always_comb begin
    if (big || (quo > Q_SAT_LIM)) begin
      power = POWER_MIN;
    end else begin
      power = POWER_W'(Q_ONE - quo);
    end
  end

  assign st = '{done: done, power: power};

endmodule

`default_nettype wire

// ===== hdl/piezo_hit_detector_beat_clock.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piezo_hit_detector_beat_clock
// piezo hit detector with holdoff, beat-relative hit power and a beat clock
// ----------------------------------------------------------------------------
// One tick is taken at a time and gives one result beat. A tick runs through
// the nibble-serial time unit (compares, next holdoff and beat times, beat
// offset), then for a hit through the bit-serial power divider, one quotient
// bit per cycle, and then into the output register; the next tick is taken
// only after that handoff. The result sits in an output register, so the
// next tick is taken while it waits. Registers are written over apb at 0x0
// threshold, 0x4 holdoff, 0x8 beat period, 0xc hit window.
// ----------------------------------------------------------------------------
module piezo_hit_detector_beat_clock
  import phd_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
)(
  input  wire logic               clk,
  input  wire logic               rst,
  phd_tick_if.sink                tick,
  phd_result_if.source            result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

  phd_cfg_t    cfg;
  phd_alu_st_t alu_st;
  phd_div_st_t div_st;
  phd_state_t  state, state_next;

  logic [TIME_W-1:0] hit_sum, beat_sum, mag;
  logic [TIME_W-1:0] next_hit, next_beat;
  logic [TIME_W-1:0] now_q;
  logic              cand;
  logic              hit_q, beat_q;
  logic [POWER_W-1:0] power_q;

  logic               o_valid;
  logic               o_hit;
  logic [POWER_W-1:0] o_power;
  logic               o_beat;
  logic [TIME_W-1:0]  o_time;

  logic accept, is_hit, div_start, out_load;

  phd_cfg_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  phd_serial_alu u_alu (
    .clk, .rst,
    .start     (accept),
    .now_ms    (tick.now_ms),
    .next_hit  (next_hit),
    .next_beat (next_beat),
    .hold      (cfg.hold),
    .period    (cfg.period),
    .st        (alu_st),
    .hit_sum   (hit_sum),
    .beat_sum  (beat_sum),
    .mag       (mag)
  );

  phd_divider u_div (
    .clk, .rst,
    .start  (div_start),
    .mag    (mag),
    .window (cfg.window),
    .st     (div_st)
  );

  assign is_hit = cand && alu_st.ge_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tick.ready = 1'b0;
    accept     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        tick.ready = 1'b1;
        if (tick.valid) begin
          accept     = 1'b1;
          state_next = ST_ALU;
        end
      end
      ST_ALU: begin
        if (alu_st.done) begin
          if (is_hit) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!o_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // holdoff and beat state, committed once the serial pass is done
  always_ff @(posedge clk) begin
    if (rst) begin
      next_hit  <= '0;
      next_beat <= '0;
    end else if (state == ST_ALU && alu_st.done) begin
      if (is_hit) begin
        next_hit <= hit_sum;
      end
      if (alu_st.ge_beat) begin
        next_beat <= beat_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_q <= tick.now_ms;
      cand  <= CMP_W'(tick.adc_sample) > CMP_W'(cfg.thr);
    end
    if (state == ST_ALU && alu_st.done) begin
      hit_q   <= is_hit;
      beat_q  <= alu_st.ge_beat;
      power_q <= '0;
    end
    if (state == ST_DIV && div_st.done) begin
      power_q <= div_st.power;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_hit   <= hit_q;
      o_power <= power_q;
      o_beat  <= beat_q;
      o_time  <= now_q;
    end
  end

  assign result.valid         = o_valid;
  assign result.hit_valid     = o_hit;
  assign result.hit_power     = o_power;
  assign result.beat_valid    = o_beat;
  assign result.event_time_ms = o_time;

endmodule

`default_nettype wire

// ===== hdl/phd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phd_checker
// port-level checks on the tick and result channels
// ----------------------------------------------------------------------------
module phd_checker
  import phd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               tick_valid,
  input wire logic               tick_ready,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic               res_hit,
  input wire logic [POWER_W-1:0] res_power
);

  // result beat holds while stalled
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_power) && $stable(res_hit))
    else $error("result beat dropped or changed while stalled");

  // one tick at a time
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick taken while previous tick in flight");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_hit |-> res_power == '0)
    else $error("nonzero power without a hit");

  a_power_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $signed(res_power) <= $signed(POWER_W'(16384)))
    else $error("hit power above 1.0");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind piezo_hit_detector_beat_clock phd_checker u_phd_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick.valid),
  .tick_ready (tick.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_hit    (result.hit_valid),
  .res_power  (result.hit_power)
);

`default_nettype wire

// ===== test/tb_piezo_hit_detector_beat_clock.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_piezo_hit_detector_beat_clock
// drives millisecond ticks into the hit detector and beat clock, predicts the
// hit, hit power and beat of every tick from its own copy of the holdoff and
// beat state, and checks each result beat in order. registers are rewritten
// over apb between phases; phases vary sender gaps and receiver stalls, hold
// the result side off for a long stretch, and end with time jumps that wrap.
// ----------------------------------------------------------------------------
module tb_piezo_hit_detector_beat_clock;
  import phd_pkg::*;

  localparam int ADC_BITS     = ADC_BITS_DEF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_STRETCH = 400;

  typedef struct packed {
    logic [TIME_W-1:0]   now;
    logic [ADC_BITS-1:0] adc;
  } tick_t;

  typedef struct packed {
    logic               hit;
    logic [POWER_W-1:0] power;
    logic               beat;
    logic [TIME_W-1:0]  stamp;
  } hit_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  phd_tick_if #(.ADC_BITS(ADC_BITS)) tick_ch ();
  phd_result_if result_ch ();

  piezo_hit_detector_beat_clock #(.ADC_BITS(ADC_BITS)) dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  tick_t             ticks_to_send[$];
  hit_beat_t         results_due[$];
  phd_cfg_t          cfg;
  logic [TIME_W-1:0] hit_gate_ms;
  logic [TIME_W-1:0] beat_due_ms;
  logic [TIME_W-1:0] last_now = '0;
  tick_t             next_tick;
  hit_beat_t         want;
  hit_beat_t         got;
  int                src_idle_pct = 0;
  int                snk_stall_pct = 0;
  int                err_cnt = 0;
  int                cycle_cnt = 0;
  int                taken_cnt = 0;
  int                seen_cnt = 0;
  int                hold_reqs = 0;
  int                holds_begun = 0;
  int                hold_left = 0;

  function automatic hit_beat_t detect_and_clock(input tick_t t);
    hit_beat_t         r;
    logic [TIME_W-1:0] offset;
    logic [TIME_W-1:0] mag;
    logic [63:0]       q;
    logic [63:0]       win;
    r = '0;
    r.stamp = t.now;
    if (t.now >= hit_gate_ms && t.adc > cfg.thr) begin
      r.hit = 1'b1;
      hit_gate_ms = t.now + TIME_W'(cfg.hold);
      offset = t.now - beat_due_ms;
      mag = offset[TIME_W-1] ? -offset : offset;
      win = (cfg.window == '0) ? 64'd1 : 64'(cfg.window);
      q = (64'(mag) << Q_FRAC) / win;
      if (q > 64'(Q_SAT_LIM)) begin
        r.power = POWER_MIN;
      end else begin
        r.power = POWER_W'(64'(Q_ONE) - q);
      end
    end
    if (t.now >= beat_due_ms) begin
      r.beat = 1'b1;
      beat_due_ms = beat_due_ms + TIME_W'(cfg.period);
    end
    return r;
  endfunction

  task automatic show_mismatch(input string what, input hit_beat_t e, input hit_beat_t a);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch (%s): expected hit=%0b power=%0d beat=%0b t=%0d, got hit=%0b power=%0d beat=%0b t=%0d",
               what, e.hit, $signed(e.power), e.beat, e.stamp,
               a.hit, $signed(a.power), a.beat, a.stamp);
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_piezo_hit_detector_beat_clock: FAIL");
      $finish;
    end
  end

  // result check first, then the tick taken at this edge
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.hit_valid, result_ch.hit_power, result_ch.beat_valid,
              result_ch.event_time_ms};
      if (results_due.size() == 0) begin
        show_mismatch("beat with nothing due", '0, got);
      end else begin
        want = results_due.pop_front();
        if (got !== want) show_mismatch("field", want, got);
      end
    end
    if (!rst && tick_ch.valid && tick_ch.ready) begin
      results_due.push_back(detect_and_clock('{tick_ch.now_ms, tick_ch.adc_sample}));
      taken_cnt++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else if (!tick_ch.valid || taken_cnt != seen_cnt) begin
      seen_cnt = taken_cnt;
      if (ticks_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_tick = ticks_to_send.pop_front();
        tick_ch.valid      <= 1'b1;
        tick_ch.now_ms     <= next_tick.now;
        tick_ch.adc_sample <= next_tick.adc;
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_reqs != holds_begun) begin
      holds_begun = hold_reqs;
      hold_left = HOLD_STRETCH;
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send(input logic [TIME_W-1:0] now, input int adc);
    ticks_to_send.push_back('{now, ADC_BITS'(adc)});
    last_now = now;
  endtask

  task automatic wait_idle();
    while (ticks_to_send.size() != 0 || tick_ch.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input phd_reg_t idx, input int unsigned val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_THRESHOLD: cfg.thr    = THR_W'(val);
      REG_HOLDOFF:   cfg.hold   = MS_W'(val);
      REG_PERIOD:    cfg.period = MS_W'(val);
      REG_WINDOW:    cfg.window = MS_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(input int thr, input int hold, input int period, input int win_ms);
    wait_idle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_HOLDOFF, hold);
    write_reg(REG_PERIOD, period);
    write_reg(REG_WINDOW, win_ms);
  endtask

  task automatic run_phase(input int thr, input int hold, input int period, input int win_ms,
                           input int src_pct, input int snk_pct, input int count,
                           input bit squeeze);
    int gap_max;
    int gap;
    int roll;
    int adc;
    set_config(thr, hold, period, win_ms);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    // bring time close to the pending beat so hit power spreads over the window
    if (beat_due_ms > last_now + TIME_W'(win_ms))
      last_now = beat_due_ms - TIME_W'($urandom_range(win_ms));
    gap_max = (period / 8 > 1) ? period / 8 : 1;
    if (squeeze) hold_reqs++;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 2) wait_idle();
      roll = $urandom_range(99);
      if (roll < 10) gap = 0;
      else if (roll < 92) gap = $urandom_range(gap_max, 1);
      else gap = $urandom_range(period, 1);
      roll = $urandom_range(99);
      if (roll < 35) adc = $urandom_range(1023);
      else if (roll < 70) adc = thr + $urandom_range(4) - 2;
      else if (roll < 80) adc = 0;
      else if (roll < 90) adc = 1023;
      else adc = $urandom_range(31);
      if (adc < 0) adc = 0;
      if (adc > 1023) adc = 1023;
      send(last_now + TIME_W'(gap), adc);
    end
  endtask

  initial begin
    int per;
    int src_pct[4];
    int snk_pct[4];
    src_pct = '{0, 49, 0, 18};
    snk_pct = '{0, 0, 49, 18};
    tick_ch.valid = 1'b0;
    tick_ch.now_ms = '0;
    tick_ch.adc_sample = '0;
    result_ch.ready = 1'b0;
    cfg = '{thr: THR_RST, hold: HOLD_RST, period: PERIOD_RST, window: WINDOW_RST};
    hit_gate_ms = '0;
    beat_due_ms = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: threshold edge, holdoff, power on both sides of the beat
    send(0, 0);
    send(0, 16);
    send(1, 1023);
    send(153, 15);
    send(153, 16);
    send(612, 1023);
    send(700, 1023);
    send(765, 1023);
    // unit window: saturation edge and no holdoff
    set_config(0, 0, 612, 1);
    send(1224, 1);
    send(1832, 1);
    send(1833, 1);
    send(1834, 1);
    send(1836, 0);
    // zero window counts as one
    set_config(0, 0, 612, 0);
    send(2447, 1);
    send(2448, 1);
    // top threshold never hits, zero period beats on every late tick
    set_config(1023, 153, 0, 306);
    send(2449, 1023);
    send(3060, 1023);
    send(3061, 1023);
    send(3061, 1023);

    for (int ph = 0; ph < 4; ph++) begin
      per = $urandom_range(1500, 40);
      run_phase($urandom_range(200), $urandom_range(400), per, $urandom_range(2 * per, 1),
                src_pct[ph], snk_pct[ph], 150, 1'b0);
    end
    run_phase(0, 0, 1, 1, 18, 18, 60, 1'b0);
    run_phase(1022, 65535, 65535, 65535, 18, 18, 60, 1'b0);
    per = $urandom_range(1000, 100);
    run_phase($urandom_range(100), $urandom_range(200), per, $urandom_range(per, 1),
              0, 0, 80, 1'b1);

    // half-range beat offset, then holdoff wrapping past the top of time
    set_config(0, 100, 612, 306);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send(beat_due_ms + 32'h8000_0000, 1023);
    send(32'hFFFF_FFF0, 1023);
    send(32'hFFFF_FFF8, 1023);
    send(32'hFFFF_FFFF, 0);
    send(32'hFFFF_FFFF, 1023);

    wait_idle();
    if (err_cnt == 0 && results_due.size() == 0) begin
      $display("tb_piezo_hit_detector_beat_clock: PASS");
    end else begin
      $display("tb_piezo_hit_detector_beat_clock: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
